FILE: rtl/ttfn_pkg.sv
package ttfn_pkg;

    // field widths
    localparam int POS_W  = 32;
    localparam int NRM_W  = 16;
    localparam int COL_W  = 24;
    localparam int LANES  = 9;
    localparam int IN_W   = LANES * POS_W;
    localparam int OUT_W  = 3 * POS_W + 3 * NRM_W + COL_W;

    // rounded divide by thirty: floor((v + 15 + 30*K) / 2 * inv15) - K
    localparam logic [33:0] DIV_BIAS  = 34'd4026531855;
    localparam logic [31:0] DIV_K     = 32'd134217728;
    localparam logic [31:0] DIV_MAGIC = 32'h88888889;
    localparam int          DIV_SHIFT = 35;

    // scene offsets in q16.16
    localparam logic [31:0] OFF_X = 32'd65536;
    localparam logic [31:0] OFF_Y = 32'd83558;
    localparam logic [31:0] OFF_Z = 32'hFFFE0000;

    // normal arithmetic
    localparam int MAG_W  = 30;
    localparam int SUM_W  = 62;
    localparam int ROOT_W = 31;
    localparam int REM_W  = 33;
    localparam int QUO_W  = 15;
    localparam int NORM_TOP = 29;

    // pipeline depths
    localparam int MAP_STAGES   = 3;
    localparam int CROSS_STAGES = 7;
    localparam int SQRT_STAGES  = ROOT_W;
    localparam int DIV_STAGES   = QUO_W + 2;
    localparam int NORM_LAT     = CROSS_STAGES + SQRT_STAGES + DIV_STAGES;

    // register indexes
    localparam logic [1:0] REG_RED   = 2'd0;
    localparam logic [1:0] REG_GREEN = 2'd1;
    localparam logic [1:0] REG_BLUE  = 2'd2;

    // normal job handed from cross product to normalizer
    typedef struct packed {
        logic [2:0]             neg;
        logic                   zero;
        logic [2:0][MAG_W-1:0]  mag;
        logic [SUM_W-1:0]       sum;
    } t_nrm_ctl;

    // output beat of a triangle
    typedef enum logic [2:0] {
        BEAT_A = 3'b001,
        BEAT_B = 3'b010,
        BEAT_C = 3'b100
    } t_beat;

endpackage

FILE: rtl/ttfn_map.sv
module ttfn_map (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_valid,
    input  logic [8:0][ttfn_pkg::POS_W-1:0]      i_raw,
    output logic                                 o_valid,
    output logic [8:0][ttfn_pkg::POS_W-1:0]      o_pos
);

    logic [2:0]        r_v;
    logic [8:0][31:0]  r_h;
    logic [8:0][63:0]  r_p;
    logic [8:0][31:0]  r_pos;
    logic [8:0][31:0]  n_h;
    logic [8:0][31:0]  n_pos;

    // per lane: pick source, negate for z, bias, halve; later scale and offset
    for (genvar l = 0; l < 9; l++) begin : g_lane
        localparam int J   = l % 3;
        localparam int SRC = (J == 0) ? l : ((J == 1) ? l + 1 : l - 1);
        logic signed [32:0] v_ext;
        logic signed [33:0] w;
        logic [31:0]        off;
        assign v_ext = (J == 2) ? -$signed({i_raw[SRC][31], i_raw[SRC]})
                                :  $signed({i_raw[SRC][31], i_raw[SRC]});
        assign w     = $signed({v_ext[32], v_ext}) + $signed(ttfn_pkg::DIV_BIAS);
        assign n_h[l] = w[32:1];
        assign off   = (J == 0) ? ttfn_pkg::OFF_X
                     : ((J == 1) ? ttfn_pkg::OFF_Y : ttfn_pkg::OFF_Z);
        assign n_pos[l] = 32'({3'b000, r_p[l][63:ttfn_pkg::DIV_SHIFT]})
                        - ttfn_pkg::DIV_K + off;
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    // datapath stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_h <= n_h;
            for (int l = 0; l < 9; l++) begin
                r_p[l] <= r_h[l] * ttfn_pkg::DIV_MAGIC;
            end
            r_pos <= n_pos;
        end
    end

    assign o_valid = r_v[2];
    assign o_pos   = r_pos;

endmodule

FILE: rtl/ttfn_cross.sv
module ttfn_cross (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_valid,
    input  logic [8:0][ttfn_pkg::POS_W-1:0]  i_pos,
    output logic                             o_valid,
    output ttfn_pkg::t_nrm_ctl               o_ctl
);

    logic [6:0]         r_v;
    logic signed [32:0] r_u [3];
    logic signed [32:0] r_w [3];
    logic signed [65:0] r_p [6];
    logic [66:0]        r_m [3];
    logic [2:0]         r_neg3;
    logic [66:0]        r_m4 [3];
    logic [2:0]         r_neg4;
    logic [6:0]         r_idx;
    logic               r_zero4;
    ttfn_pkg::t_nrm_ctl r_c5;
    logic [59:0]        r_sq [3];
    ttfn_pkg::t_nrm_ctl r_c6;
    ttfn_pkg::t_nrm_ctl r_c7;

    logic signed [66:0] c [3];
    logic [66:0]        n_m [3];
    logic [66:0]        orv;
    logic [6:0]         n_idx;
    logic [2:0][29:0]   n_sh;

    // cross product components and magnitudes
    always_comb begin
        c[0] = 67'(r_p[0]) - 67'(r_p[1]);
        c[1] = 67'(r_p[2]) - 67'(r_p[3]);
        c[2] = 67'(r_p[4]) - 67'(r_p[5]);
        for (int i = 0; i < 3; i++) begin
            n_m[i] = c[i][66] ? 67'(-c[i]) : 67'(c[i]);
        end
    end

    // leading one of the largest magnitude
    always_comb begin
        orv   = r_m[0] | r_m[1] | r_m[2];
        n_idx = '0;
        for (int b = 0; b < 67; b++) begin
            if (orv[b]) begin
                n_idx = 7'(b);
            end
        end
    end

    // common shift so the largest lands in [2^29, 2^30)
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_idx >= 7'(ttfn_pkg::NORM_TOP)) begin
                n_sh[i] = 30'(r_m4[i] >> 7'(r_idx - 7'(ttfn_pkg::NORM_TOP)));
            end else begin
                n_sh[i] = 30'(r_m4[i] << 7'(7'(ttfn_pkg::NORM_TOP) - r_idx));
            end
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[5:0], i_valid};
        end
    end

    // datapath stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_u[i] <= 33'($signed(i_pos[3 + i])) - 33'($signed(i_pos[6 + i]));
                r_w[i] <= 33'($signed(i_pos[3 + i])) - 33'($signed(i_pos[i]));
            end
            r_p[0] <= r_u[1] * r_w[2];
            r_p[1] <= r_u[2] * r_w[1];
            r_p[2] <= r_u[2] * r_w[0];
            r_p[3] <= r_u[0] * r_w[2];
            r_p[4] <= r_u[0] * r_w[1];
            r_p[5] <= r_u[1] * r_w[0];
            r_m    <= n_m;
            r_neg3 <= {c[2][66], c[1][66], c[0][66]};
            r_m4    <= r_m;
            r_neg4  <= r_neg3;
            r_idx   <= n_idx;
            r_zero4 <= (orv == '0);
            r_c5.neg  <= r_neg4;
            r_c5.zero <= r_zero4;
            r_c5.mag  <= n_sh;
            r_c5.sum  <= '0;
            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= r_c5.mag[i] * r_c5.mag[i];
            end
            r_c6 <= r_c5;
            r_c7.neg  <= r_c6.neg;
            r_c7.zero <= r_c6.zero;
            r_c7.mag  <= r_c6.mag;
            r_c7.sum  <= 62'(r_sq[0]) + 62'(r_sq[1]) + 62'(r_sq[2]);
        end
    end

    assign o_valid = r_v[6];
    assign o_ctl   = r_c7;

endmodule

FILE: rtl/ttfn_norm.sv
module ttfn_norm (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_valid,
    input  ttfn_pkg::t_nrm_ctl               i_ctl,
    output logic                             o_valid,
    output logic [2:0][ttfn_pkg::NRM_W-1:0]  o_nrm
);

    localparam int SQ = ttfn_pkg::SQRT_STAGES;
    localparam int DQ = ttfn_pkg::QUO_W;

    // square root stages
    logic [SQ-1:0]                  r_sv;
    logic [ttfn_pkg::REM_W-1:0]     r_rem  [SQ];
    logic [ttfn_pkg::ROOT_W-1:0]    r_root [SQ];
    ttfn_pkg::t_nrm_ctl             r_sc   [SQ];

    for (genvar s = 0; s < SQ; s++) begin : g_sqrt
        localparam int D = SQ - 1 - s;
        logic [ttfn_pkg::REM_W-1:0]  p_rem;
        logic [ttfn_pkg::ROOT_W-1:0] p_root;
        ttfn_pkg::t_nrm_ctl          p_c;
        logic                        p_v;
        logic [34:0]                 cur;
        logic [34:0]                 trial;
        if (s == 0) begin : g_head
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_c    = i_ctl;
            assign p_v    = i_valid;
        end else begin : g_body
            assign p_rem  = r_rem[s-1];
            assign p_root = r_root[s-1];
            assign p_c    = r_sc[s-1];
            assign p_v    = r_sv[s-1];
        end
        assign cur   = {p_rem, p_c.sum[2*D+1 -: 2]};
        assign trial = {2'b00, p_root, 2'b01};
        // one root digit per stage
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[s] <= 1'b0;
            end else if (i_en) begin
                r_sv[s] <= p_v;
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sc[s] <= p_c;
                if (cur >= trial) begin
                    r_rem[s]  <= 33'(cur - trial);
                    r_root[s] <= {p_root[ttfn_pkg::ROOT_W-2:0], 1'b1};
                end else begin
                    r_rem[s]  <= 33'(cur);
                    r_root[s] <= {p_root[ttfn_pkg::ROOT_W-2:0], 1'b0};
                end
            end
        end
    end

    // divider setup: numerator and doubled length
    logic               r_dv0;
    logic [2:0][45:0]   r_num0;
    logic [31:0]        r_den0;
    logic [2:0]         r_neg0;
    logic               r_zero0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv0 <= 1'b0;
        end else if (i_en) begin
            r_dv0 <= r_sv[SQ-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_num0[i] <= 46'({r_sc[SQ-1].mag[i], 15'b0})
                           + 46'(r_root[SQ-1]);
            end
            r_den0  <= {r_root[SQ-1], 1'b0};
            r_neg0  <= r_sc[SQ-1].neg;
            r_zero0 <= r_sc[SQ-1].zero;
        end
    end

    // restoring division, one quotient bit per stage
    logic [DQ-1:0]        r_dv;
    logic [2:0][45:0]     r_num [DQ];
    logic [2:0][DQ-1:0]   r_q   [DQ];
    logic [31:0]          r_den [DQ];
    logic [2:0]           r_neg [DQ];
    logic [DQ-1:0]        r_zero;

    for (genvar t = 0; t < DQ; t++) begin : g_div
        localparam int B = DQ - 1 - t;
        logic               p_v;
        logic [2:0][45:0]   p_num;
        logic [2:0][DQ-1:0] p_q;
        logic [31:0]        p_den;
        logic [2:0]         p_neg;
        logic               p_zero;
        logic [46:0]        dsh;
        if (t == 0) begin : g_head
            assign p_v    = r_dv0;
            assign p_num  = r_num0;
            assign p_q    = '0;
            assign p_den  = r_den0;
            assign p_neg  = r_neg0;
            assign p_zero = r_zero0;
        end else begin : g_body
            assign p_v    = r_dv[t-1];
            assign p_num  = r_num[t-1];
            assign p_q    = r_q[t-1];
            assign p_den  = r_den[t-1];
            assign p_neg  = r_neg[t-1];
            assign p_zero = r_zero[t-1];
        end
        assign dsh = 47'(p_den) << B;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[t] <= 1'b0;
            end else if (i_en) begin
                r_dv[t] <= p_v;
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[t]  <= p_den;
                r_neg[t]  <= p_neg;
                r_zero[t] <= p_zero;
                for (int i = 0; i < 3; i++) begin
                    if (47'(p_num[i]) >= dsh) begin
                        r_num[t][i] <= 46'(47'(p_num[i]) - dsh);
                        r_q[t][i]   <= p_q[i] | (DQ'(1) << B);
                    end else begin
                        r_num[t][i] <= p_num[i];
                        r_q[t][i]   <= p_q[i];
                    end
                end
            end
        end
    end

    // sign restore, degenerate face gives zero
    logic               r_ov;
    logic [2:0][15:0]   r_nrm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_ov <= r_dv[DQ-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                if (r_zero[DQ-1]) begin
                    r_nrm[i] <= '0;
                end else if (r_neg[DQ-1][i]) begin
                    r_nrm[i] <= 16'(-{1'b0, r_q[DQ-1][i]});
                end else begin
                    r_nrm[i] <= {1'b0, r_q[DQ-1][i]};
                end
            end
        end
    end

    assign o_valid = r_ov;
    assign o_nrm   = r_nrm;

endmodule

FILE: rtl/ttfn_ser.sv
module ttfn_ser (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    input  logic [8:0][ttfn_pkg::POS_W-1:0]      i_pos,
    input  logic [2:0][ttfn_pkg::NRM_W-1:0]      i_nrm,
    input  logic [ttfn_pkg::COL_W-1:0]           i_color,
    input  logic                                 i_m_tready,
    output logic                                 o_en,
    output logic                                 o_m_tvalid,
    output logic [ttfn_pkg::OUT_W-1:0]           o_m_tdata,
    output logic                                 o_m_tlast
);

    logic                   r_full;
    ttfn_pkg::t_beat        r_beat;
    logic [8:0][31:0]       r_pos;
    logic [2:0][15:0]       r_nrm;
    logic                   take;
    logic [2:0][31:0]       cur_pos;

    // pipeline moves when the holding register is empty or drains its last word
    assign take = !r_full || (i_m_tready && (r_beat == ttfn_pkg::BEAT_C));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
            r_beat <= ttfn_pkg::BEAT_A;
        end else if (take) begin
            r_full <= i_valid;
            r_beat <= ttfn_pkg::BEAT_A;
        end else if (i_m_tready) begin
            case (r_beat)
                ttfn_pkg::BEAT_A: r_beat <= ttfn_pkg::BEAT_B;
                ttfn_pkg::BEAT_B: r_beat <= ttfn_pkg::BEAT_C;
                default:          r_beat <= ttfn_pkg::BEAT_A;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_pos <= i_pos;
            r_nrm <= i_nrm;
        end
    end

    // corner select
    always_comb begin
        case (r_beat)
            ttfn_pkg::BEAT_A: cur_pos = r_pos[2:0];
            ttfn_pkg::BEAT_B: cur_pos = r_pos[5:3];
            ttfn_pkg::BEAT_C: cur_pos = r_pos[8:6];
            default:          cur_pos = r_pos[2:0];
        endcase
    end

    assign o_en       = take;
    assign o_m_tvalid = r_full;
    assign o_m_tdata  = {i_color, r_nrm, cur_pos};
    assign o_m_tlast  = (r_beat == ttfn_pkg::BEAT_C);

endmodule

FILE: rtl/triangle_transform_flat_normal.sv
// a triangle passes the map, cross and norm pipelines, then the output word register
// three vertex words per triangle on one output channel; input is held until the last drains
// the pipeline takes an item every cycle unless frozen; the output register sets the rate
// a stall on the output freezes the whole pipeline, nothing is lost or repeated
// reset is synchronous and active low: clears valid bits and sets all colors to 255
module triangle_transform_flat_normal (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // first_x, first_y, first_z, second_x, second_y, second_z, third_x, third_y, third_z
    input  logic [ttfn_pkg::IN_W-1:0]      i_s_tdata,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, color_packed
    output logic [ttfn_pkg::OUT_W-1:0]     o_m_tdata,
    output logic                           o_m_tlast,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [1:0]                     i_cfg_index,
    input  logic [7:0]                     i_cfg_data
);

    logic [7:0]         r_red;
    logic [7:0]         r_green;
    logic [7:0]         r_blue;
    logic               en;
    logic               map_v;
    logic [8:0][31:0]   map_pos;
    logic               cross_v;
    ttfn_pkg::t_nrm_ctl cross_ctl;
    logic               norm_v;
    logic [2:0][15:0]   norm_nrm;
    logic [8:0][31:0]   r_dly [ttfn_pkg::NORM_LAT];

    // color registers
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red   <= 8'hFF;
            r_green <= 8'hFF;
            r_blue  <= 8'hFF;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ttfn_pkg::REG_RED:   r_red   <= i_cfg_data;
                ttfn_pkg::REG_GREEN: r_green <= i_cfg_data;
                ttfn_pkg::REG_BLUE:  r_blue  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_s_tready = en;

    ttfn_map u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_s_tvalid),
        .i_raw   (i_s_tdata),
        .o_valid (map_v),
        .o_pos   (map_pos)
    );

    ttfn_cross u_cross (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (map_v),
        .i_pos   (map_pos),
        .o_valid (cross_v),
        .o_ctl   (cross_ctl)
    );

    ttfn_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (cross_v),
        .i_ctl   (cross_ctl),
        .o_valid (norm_v),
        .o_nrm   (norm_nrm)
    );

    // positions wait alongside the normal computation
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dly[0] <= map_pos;
            for (int i = 1; i < ttfn_pkg::NORM_LAT; i++) begin
                r_dly[i] <= r_dly[i-1];
            end
        end
    end

    ttfn_ser u_ser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (norm_v),
        .i_pos      (r_dly[ttfn_pkg::NORM_LAT-1]),
        .i_nrm      (norm_nrm),
        .i_color    ({r_red, r_green, r_blue}),
        .i_m_tready (i_m_tready),
        .o_en       (en),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

FILE: rtl/ttfn_chk.sv
module ttfn_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_s_tready,
    input logic                        o_m_tvalid,
    input logic                        i_m_tready,
    input logic [ttfn_pkg::OUT_W-1:0]  o_m_tdata,
    input logic                        o_m_tlast
);

    // a stalled word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("output word changed while stalled");

    // the three corners of a triangle follow back to back with one normal
    a_shared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready && !o_m_tlast |=>
            o_m_tvalid && (o_m_tdata[143:96] == $past(o_m_tdata[143:96])))
        else $error("normal differs between corners");

    // a stalled output blocks the input side
    a_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |-> !o_s_tready)
        else $error("input taken while output stalled");

    // normal components stay within unit length
    a_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |->
            ($signed(o_m_tdata[111:96]) <= 16'sd16384)
         && ($signed(o_m_tdata[111:96]) >= -16'sd16384)
         && ($signed(o_m_tdata[127:112]) <= 16'sd16384)
         && ($signed(o_m_tdata[127:112]) >= -16'sd16384)
         && ($signed(o_m_tdata[143:128]) <= 16'sd16384)
         && ($signed(o_m_tdata[143:128]) >= -16'sd16384))
        else $error("normal component out of range");

endmodule

bind triangle_transform_flat_normal ttfn_chk u_chk (.*);

FILE: tb/tb_triangle_transform_flat_normal.sv
`timescale 1ns / 100ps

module tb_triangle_transform_flat_normal;

    localparam int IDLE_LIMIT = 4000;
    localparam int DRAIN_WAIT = 80;
    localparam logic [1:0] REG_NONE = 2'd3;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_s_tvalid;
    logic                          o_s_tready;
    logic [ttfn_pkg::IN_W-1:0]     i_s_tdata;
    logic                          o_m_tvalid;
    logic                          i_m_tready;
    logic [ttfn_pkg::OUT_W-1:0]    o_m_tdata;
    logic                          o_m_tlast;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [1:0]                    i_cfg_index;
    logic [7:0]                    i_cfg_data;

    triangle_transform_flat_normal dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // color registers as the block should hold them
    logic [7:0] red_lvl, green_lvl, blue_lvl;

    // expected vertex words, {last, tdata}
    logic [ttfn_pkg::OUT_W:0] vertex_q[$];

    int errors;
    int tri_sent;
    int vtx_seen;
    int cfg_writes;
    int hold_req;
    int stall_pct;

    // clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // nearest of a/30, ties upward
    function automatic longint div30_round(input longint a);
        longint num;
        num = 2 * a + 30;
        if (num >= 0) return num / 60;
        return -((-num + 59) / 60);
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned val);
        longint unsigned res, bitv, v;
        v = val;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // map the corners, form the flat normal, queue three vertex words
    task automatic queue_triangle(input logic [ttfn_pkg::IN_W-1:0] tri_w);
        longint p[3][3];
        longint u[3], v[3], c[3];
        longint unsigned mag[3], m, sum, len, q;
        logic [ttfn_pkg::NRM_W-1:0] nrm[3];
        int up, down;
        logic [ttfn_pkg::OUT_W-1:0] w;
        for (int k = 0; k < 3; k++) begin
            p[k][0] = div30_round(longint'($signed(tri_w[(3*k)*32 +: 32]))) + 65536;
            p[k][1] = div30_round(longint'($signed(tri_w[(3*k+2)*32 +: 32]))) + 83558;
            p[k][2] = div30_round(-longint'($signed(tri_w[(3*k+1)*32 +: 32]))) - 131072;
        end
        for (int i = 0; i < 3; i++) begin
            u[i] = p[1][i] - p[2][i];
            v[i] = p[1][i] - p[0][i];
        end
        c[0] = u[1] * v[2] - u[2] * v[1];
        c[1] = u[2] * v[0] - u[0] * v[2];
        c[2] = u[0] * v[1] - u[1] * v[0];
        m = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = c[i] < 0 ? longint'(-c[i]) : longint'(c[i]);
            if (mag[i] > m) m = mag[i];
        end
        if (m == 0) begin
            for (int i = 0; i < 3; i++) nrm[i] = '0;
        end else begin
            up = 0;
            down = 0;
            while (m < (64'd1 << 29)) begin
                m = m << 1;
                up++;
            end
            while (m >= (64'd1 << 30)) begin
                m = m >> 1;
                down++;
            end
            sum = 0;
            for (int i = 0; i < 3; i++) begin
                mag[i] = (mag[i] << up) >> down;
                sum += mag[i] * mag[i];
            end
            len = int_sqrt(sum);
            for (int i = 0; i < 3; i++) begin
                q = (mag[i] * 64'd32768 + len) / (2 * len);
                nrm[i] = c[i] < 0 ? -q[ttfn_pkg::NRM_W-1:0] : q[ttfn_pkg::NRM_W-1:0];
            end
        end
        for (int k = 0; k < 3; k++) begin
            w = {red_lvl, green_lvl, blue_lvl, nrm[2], nrm[1], nrm[0],
                 p[k][2][31:0], p[k][1][31:0], p[k][0][31:0]};
            vertex_q.insert(vertex_q.size(), {(k == 2), w});
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // offer one triangle word, wait for it to be taken
    task automatic send_triangle(input logic [ttfn_pkg::IN_W-1:0] tri_w, input bit gaps);
        int gap;
        gap = gaps ? pick_gap() : 0;
        if (gap > 0) begin
            i_s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tdata  = tri_w;
        i_s_tvalid = 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        queue_triangle(tri_w);
        tri_sent++;
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        i_cfg_index = idx;
        i_cfg_data  = val;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            ttfn_pkg::REG_RED:   red_lvl   = val;
            ttfn_pkg::REG_GREEN: green_lvl = val;
            ttfn_pkg::REG_BLUE:  blue_lvl  = val;
            default: ;
        endcase
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // stop offering and wait until every expected word is out
    task automatic drain();
        i_s_tvalid = 1'b0;
        while (vertex_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_coord();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return $urandom;
        if (r < 85) return 32'($signed($urandom_range(0, 2000000)) - 1000000);
        if (r < 93) return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
        return 32'($signed($urandom_range(0, 60)) - 30);
    endfunction

    function automatic logic [ttfn_pkg::IN_W-1:0] rand_triangle();
        logic [ttfn_pkg::IN_W-1:0] t;
        int r;
        for (int i = 0; i < ttfn_pkg::LANES; i++) t[i*32 +: 32] = rand_coord();
        r = $urandom_range(0, 99);
        // degenerate shapes: repeated corner or all corners equal
        if (r < 6) t[3*32 +: 96] = t[0 +: 96];
        else if (r < 9) begin
            t[3*32 +: 96] = t[0 +: 96];
            t[6*32 +: 96] = t[0 +: 96];
        end
        return t;
    endfunction

    function automatic logic [ttfn_pkg::IN_W-1:0] fill_triangle(input logic [31:0] v);
        logic [ttfn_pkg::IN_W-1:0] t;
        for (int i = 0; i < ttfn_pkg::LANES; i++) t[i*32 +: 32] = v;
        return t;
    endfunction

    // extremes, degenerate shapes, axis-aligned faces, then six random triangles with gaps
    task automatic test_directed();
        logic [ttfn_pkg::IN_W-1:0] t;
        send_triangle('0, 0);
        send_triangle(fill_triangle(32'h7FFFFFFF), 0);
        send_triangle(fill_triangle(32'h80000000), 0);
        send_triangle(fill_triangle(32'hFFFFFFFF), 0);
        t = '0;
        t[3*32 +: 32] = 32'h7FFFFFFF;
        t[6*32 +: 32] = 32'h80000000;
        send_triangle(t, 0);
        for (int a = 0; a < 3; a++) begin
            t = '0;
            t[(3 + a)*32 +: 32] = 32'h00010000;
            t[(6 + (a + 1) % 3)*32 +: 32] = 32'h00010000;
            send_triangle(t, 0);
            t = '0;
            t[(3 + a)*32 +: 32] = 32'h80000000;
            t[(6 + (a + 1) % 3)*32 +: 32] = 32'h7FFFFFFF;
            send_triangle(t, 0);
        end
        for (int i = 0; i < ttfn_pkg::LANES; i++) begin
            t[i*32 +: 32] = (i % 2) ? 32'h7FFFFFFF : 32'h80000000;
        end
        send_triangle(t, 0);
        for (int i = 0; i < ttfn_pkg::LANES; i++) t[i*32 +: 32] = 32'(i * 15 - 45);
        send_triangle(t, 0);
        for (int i = 0; i < 6; i++) send_triangle(rand_triangle(), 1);
        drain();
    endtask

    // color registers at extremes and fixed patterns, bad index included with random data
    task automatic test_colors();
        logic [7:0] set_vals[4];
        set_vals = '{8'h00, 8'hFF, 8'h5A, 8'hA5};
        for (int s = 0; s < 4; s++) begin
            write_reg(ttfn_pkg::REG_RED, set_vals[s]);
            write_reg(ttfn_pkg::REG_GREEN, set_vals[(s + 1) % 4]);
            write_reg(ttfn_pkg::REG_BLUE, set_vals[(s + 2) % 4]);
            write_reg(REG_NONE, 8'($urandom));
            for (int i = 0; i < 4; i++) send_triangle(rand_triangle(), 1);
            drain();
        end
    endtask

    // random triangles in phases with new colors between them
    task automatic test_random(input int count);
        for (int ph = 0; ph < 4; ph++) begin
            stall_pct = (ph == 0) ? 0 : $urandom_range(10, 60);
            write_reg(ttfn_pkg::REG_RED, 8'($urandom));
            write_reg(ttfn_pkg::REG_GREEN, 8'($urandom));
            write_reg(ttfn_pkg::REG_BLUE, 8'($urandom));
            for (int i = 0; i < count / 4; i++) send_triangle(rand_triangle(), ph != 0);
            drain();
        end
        stall_pct = 20;
    endtask

    // receiver holds off long while triangles keep coming
    task automatic test_backpressure();
        hold_req++;
        for (int i = 0; i < 80; i++) send_triangle(rand_triangle(), 0);
        // sender pauses until the block is empty, then resumes
        i_s_tvalid = 1'b0;
        while (vertex_q.size() != 0) @(negedge i_clk);
        for (int i = 0; i < 10; i++) send_triangle(rand_triangle(), 1);
        drain();
    endtask

    // receiver ready, random stalls and a counted long hold-off
    initial begin : rx_ready
        int hold_cnt;
        int hold_seen;
        hold_cnt = 0;
        hold_seen = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_cnt = 400;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                i_m_tready = 1'b0;
            end else if ($urandom_range(0, 99) < 4) begin
                i_m_tready = 1'b0;
                hold_cnt = $urandom_range(10, 40);
            end else begin
                i_m_tready = ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // check each vertex word against the oldest expectation
    always @(posedge i_clk) begin
        logic [ttfn_pkg::OUT_W:0] exp_w;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            vtx_seen++;
            if (vertex_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected word %h", o_m_tdata);
            end else begin
                exp_w = vertex_q.pop_front();
                if ({o_m_tlast, o_m_tdata} !== exp_w) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("mismatch word %0d: pos exp %h/%h/%h got %h/%h/%h", vtx_seen,
                            exp_w[0 +: 32], exp_w[32 +: 32], exp_w[64 +: 32],
                            o_m_tdata[0 +: 32], o_m_tdata[32 +: 32], o_m_tdata[64 +: 32]);
                        $display("  norm exp %h/%h/%h got %h/%h/%h", exp_w[96 +: 16],
                            exp_w[112 +: 16], exp_w[128 +: 16], o_m_tdata[96 +: 16],
                            o_m_tdata[112 +: 16], o_m_tdata[128 +: 16]);
                        $display("  color exp %h got %h, last exp %b got %b",
                            exp_w[144 +: 24], o_m_tdata[144 +: 24], exp_w[ttfn_pkg::OUT_W],
                            o_m_tlast);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge i_clk) begin
        int idle_cnt;
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cnt = 0;
        end else begin
            idle_cnt++;
            if (idle_cnt >= IDLE_LIMIT) begin
                $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
                $display("tb_triangle_transform_flat_normal: done, errors");
                $finish;
            end
        end
    end

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_m_tready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        red_lvl = 8'hFF;
        green_lvl = 8'hFF;
        blue_lvl = 8'hFF;
        errors = 0;
        tri_sent = 0;
        vtx_seen = 0;
        cfg_writes = 0;
        hold_req = 0;
        stall_pct = 20;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_directed();
        test_colors();
        test_random(180);
        test_backpressure();
        drain();

        if (vertex_q.size() != 0) begin
            errors++;
            $display("%0d expected words never arrived", vertex_q.size());
        end
        $display("covered %0d triangles, %0d vertex words, %0d color writes",
                 tri_sent, vtx_seen, cfg_writes);
        $display("with extremes, degenerate faces, random stalls and a long output hold-off");
        if (errors == 0) begin
            $display("tb_triangle_transform_flat_normal: done, clean");
        end else begin
            $display("tb_triangle_transform_flat_normal: done, errors");
        end
        $finish;
    end

endmodule
